@@ hdl/tcw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Field widths
    localparam int ACTION_W    = 2;
    localparam int CHAR_W      = 8;
    localparam int COLOR_W     = 4;
    localparam int ROW_FIELD_W = 5;
    localparam int COL_FIELD_W = 7;
    localparam int CELL_W      = 16;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_PRINT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0020;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCROLL,
        ST_BLANK,
        ST_EMIT
    } tcw_state_t;

    // Finished result handed from the controller to the output register
    typedef struct packed {
        logic                   valid;
        logic [CELL_W-1:0]      cell_value;
        logic [ROW_FIELD_W-1:0] cursor_row;
        logic [COL_FIELD_W-1:0] cursor_column;
        logic                   scrolled;
    } tcw_result_t;

endpackage

@@ hdl/text_console_writer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text console of ROWS x COLUMNS character cells with cursor, scroll and clear.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata fields (low bit up)                   | tuser
//  s_axis   | in        | character, fg_color, bg_color, read_row,    | action
//           |           | read_column                                 |
//  m_axis   | out       | cell_value, cursor_row, cursor_column,      | -
//           |           | scrolled                                    |
//
// Print without scroll, read and unused actions go from idle straight to emit.
// Clear blanks every cell, one cell store write per cycle, then emits.
// A print that scrolls copies each row up one row and then blanks the bottom
// row; the row copy and the bottom row blank share the single write port of
// the cell store. After reset a fill pass blanks the store; no transfer
// is accepted until it ends. A stalled result holds in the output register.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // character[7:0], fg_color[11:8], bg_color[15:12], read_row[20:16],
    // read_column[27:21]
    input  logic [31:0] s_axis_tdata,
    // action[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cell_value[15:0], cursor_row[20:16], cursor_column[27:21], scrolled[28]
    output logic [31:0] m_axis_tdata
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    logic                       m_valid_reg;
    logic [31:0]                m_data_reg;
    logic                       out_free;
    tcw_pkg::tcw_result_t       result;

    logic                       ram_wr_en;
    logic [ADDR_W-1:0]          ram_wr_addr;
    logic [tcw_pkg::CELL_W-1:0] ram_wr_data;
    logic                       ram_rd_en;
    logic [ADDR_W-1:0]          ram_rd_addr;
    logic [tcw_pkg::CELL_W-1:0] ram_rd_data;

    assign out_free = !m_valid_reg || m_axis_tready;

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .ADDR_W  (ADDR_W)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_action      (s_axis_tuser),
        .in_character   (s_axis_tdata[7:0]),
        .in_fg_color    (s_axis_tdata[11:8]),
        .in_bg_color    (s_axis_tdata[15:12]),
        .in_read_row    (s_axis_tdata[20:16]),
        .in_read_column (s_axis_tdata[27:21]),
        .out_free       (out_free),
        .result         (result),
        .ram_wr_en      (ram_wr_en),
        .ram_wr_addr    (ram_wr_addr),
        .ram_wr_data    (ram_wr_data),
        .ram_rd_en      (ram_rd_en),
        .ram_rd_addr    (ram_rd_addr),
        .ram_rd_data    (ram_rd_data)
    );

    tcw_cell_ram #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W)
    ) u_cell_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Output register: load a finished result, hold it until the transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.valid) begin
            m_data_reg <= {3'b000, result.scrolled, result.cursor_column,
                           result.cursor_row, result.cell_value};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

@@ hdl/tcw_cell_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Character cell store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
    parameter int DEPTH  = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
    parameter int ADDR_W = $clog2(tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS)
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [tcw_pkg::CELL_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [tcw_pkg::CELL_W-1:0]  rd_data
);

    logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/tcw_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl
// Cursor, command decode and sweep sequencer for clear, scroll and reset fill.
// ----------------------------------------------------------------------------
module tcw_ctrl #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS,
    parameter int ADDR_W  = $clog2(tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [tcw_pkg::ACTION_W-1:0]    in_action,
    input  logic [tcw_pkg::CHAR_W-1:0]      in_character,
    input  logic [tcw_pkg::COLOR_W-1:0]     in_fg_color,
    input  logic [tcw_pkg::COLOR_W-1:0]     in_bg_color,
    input  logic [tcw_pkg::ROW_FIELD_W-1:0] in_read_row,
    input  logic [tcw_pkg::COL_FIELD_W-1:0] in_read_column,
    input  logic                            out_free,
    output tcw_pkg::tcw_result_t            result,
    output logic                            ram_wr_en,
    output logic [ADDR_W-1:0]               ram_wr_addr,
    output logic [tcw_pkg::CELL_W-1:0]      ram_wr_data,
    output logic                            ram_rd_en,
    output logic [ADDR_W-1:0]               ram_rd_addr,
    input  logic [tcw_pkg::CELL_W-1:0]      ram_rd_data
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLUMNS);

    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'(CELL_COUNT - COLUMNS);

    tcw_pkg::tcw_state_t state_reg, state_next;

    logic [ROW_W-1:0]  cursor_row_reg, cursor_row_next;
    logic [COL_W-1:0]  cursor_col_reg, cursor_col_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic              copy_valid_reg, copy_valid_next;
    logic [ADDR_W-1:0] copy_addr_reg, copy_addr_next;
    logic              read_hit_reg, read_hit_next;
    logic              scrolled_reg, scrolled_next;

    logic              accept;
    logic              is_newline;
    logic [ROW_W:0]    row_step;
    logic [COL_W:0]    col_step;
    logic              scroll_hit;
    logic              sweep_last;
    logic              read_in_range;
    logic [ADDR_W-1:0] cursor_addr;
    logic [ADDR_W-1:0] read_addr;
    logic [31:0]       row_wide;
    logic [31:0]       col_wide;

    assign accept     = in_valid && (state_reg == tcw_pkg::ST_IDLE);
    assign in_ready   = (state_reg == tcw_pkg::ST_IDLE);
    assign is_newline = (in_character == tcw_pkg::NEWLINE_CHAR);
    assign sweep_last = (sweep_reg == LAST_ADDR);

    assign cursor_addr = ADDR_W'(cursor_row_reg) * ROW_STRIDE + ADDR_W'(cursor_col_reg);
    assign read_addr   = ADDR_W'(in_read_row) * ROW_STRIDE + ADDR_W'(in_read_column);
    assign read_in_range = (32'(in_read_row) < ROWS) && (32'(in_read_column) < COLUMNS);

    // Cursor advance for a print item, before the scroll check
    always_comb begin
        if (is_newline) begin
            row_step = {1'b0, cursor_row_reg} + (ROW_W+1)'(1);
            col_step = '0;
        end else begin
            row_step = {1'b0, cursor_row_reg};
            col_step = {1'b0, cursor_col_reg} + (COL_W+1)'(1);
        end
        if (col_step >= (COL_W+1)'(COLUMNS)) begin
            col_step = '0;
            row_step = row_step + (ROW_W+1)'(1);
        end
        scroll_hit = (row_step >= (ROW_W+1)'(ROWS));
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tcw_pkg::ST_INIT: begin
                if (sweep_last) state_next = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::ST_IDLE: begin
                if (accept) begin
                    if (in_action == tcw_pkg::ACT_PRINT && scroll_hit) begin
                        state_next = tcw_pkg::ST_SCROLL;
                    end else if (in_action == tcw_pkg::ACT_CLEAR) begin
                        state_next = tcw_pkg::ST_BLANK;
                    end else begin
                        state_next = tcw_pkg::ST_EMIT;
                    end
                end
            end
            tcw_pkg::ST_SCROLL: begin
                if (sweep_last) state_next = tcw_pkg::ST_BLANK;
            end
            tcw_pkg::ST_BLANK: begin
                if (!copy_valid_reg && sweep_last) state_next = tcw_pkg::ST_EMIT;
            end
            tcw_pkg::ST_EMIT: begin
                if (out_free) state_next = tcw_pkg::ST_IDLE;
            end
            default: state_next = tcw_pkg::ST_INIT;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        sweep_next      = sweep_reg;
        copy_valid_next = 1'b0;
        copy_addr_next  = copy_addr_reg;
        read_hit_next   = read_hit_reg;
        scrolled_next   = scrolled_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = sweep_reg;
        ram_wr_data     = tcw_pkg::BLANK_CELL;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = read_addr;

        case (state_reg)
            tcw_pkg::ST_INIT: begin
                ram_wr_en  = 1'b1;
                sweep_next = sweep_last ? '0 : sweep_reg + ADDR_W'(1);
            end
            tcw_pkg::ST_IDLE: begin
                if (accept) begin
                    read_hit_next = 1'b0;
                    scrolled_next = 1'b0;
                    case (in_action)
                        tcw_pkg::ACT_PRINT: begin
                            if (!is_newline) begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = cursor_addr;
                                ram_wr_data = {in_bg_color, in_fg_color, in_character};
                            end
                            if (scroll_hit) begin
                                cursor_row_next = ROW_W'(ROWS - 1);
                                cursor_col_next = '0;
                                scrolled_next   = 1'b1;
                                sweep_next      = ROW_STRIDE;
                            end else begin
                                cursor_row_next = row_step[ROW_W-1:0];
                                cursor_col_next = col_step[COL_W-1:0];
                            end
                        end
                        tcw_pkg::ACT_CLEAR: begin
                            cursor_row_next = '0;
                            cursor_col_next = '0;
                            sweep_next      = '0;
                        end
                        tcw_pkg::ACT_READ: begin
                            ram_rd_en     = 1'b1;
                            read_hit_next = read_in_range;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tcw_pkg::ST_SCROLL: begin
                // Read one row below, write it back in the next cycle
                ram_rd_en       = 1'b1;
                ram_rd_addr     = sweep_reg;
                copy_valid_next = 1'b1;
                copy_addr_next  = sweep_reg - ROW_STRIDE;
                sweep_next      = sweep_last ? BOTTOM_ROW : sweep_reg + ADDR_W'(1);
                if (copy_valid_reg) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = copy_addr_reg;
                    ram_wr_data = ram_rd_data;
                end
            end
            tcw_pkg::ST_BLANK: begin
                ram_wr_en = 1'b1;
                if (copy_valid_reg) begin
                    // Finish the last copy before blanking starts
                    ram_wr_addr = copy_addr_reg;
                    ram_wr_data = ram_rd_data;
                end else begin
                    sweep_next = sweep_last ? '0 : sweep_reg + ADDR_W'(1);
                end
            end
            tcw_pkg::ST_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    assign row_wide = 32'(cursor_row_reg);
    assign col_wide = 32'(cursor_col_reg);

    always_comb begin
        result.valid         = (state_reg == tcw_pkg::ST_EMIT) && out_free;
        result.cell_value    = read_hit_reg ? ram_rd_data : '0;
        result.cursor_row    = row_wide[tcw_pkg::ROW_FIELD_W-1:0];
        result.cursor_column = col_wide[tcw_pkg::COL_FIELD_W-1:0];
        result.scrolled      = scrolled_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tcw_pkg::ST_INIT;
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            sweep_reg      <= '0;
            copy_valid_reg <= 1'b0;
            read_hit_reg   <= 1'b0;
            scrolled_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
            sweep_reg      <= sweep_next;
            copy_valid_reg <= copy_valid_next;
            read_hit_reg   <= read_hit_next;
            scrolled_reg   <= scrolled_next;
        end
    end

    always_ff @(posedge aclk) begin
        copy_addr_reg <= copy_addr_next;
    end

endmodule
